@@ hw/rtl/spq_pkg.sv @@
// Shared constants, codes and control types of the sorted priority queue.
package spq_pkg;

    // Default sizes of the queue and its fields.
    localparam int DEPTH_DEF        = 16;
    localparam int PRIO_BITS_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Request kinds.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status codes.
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    // Operation broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_if.sv @@
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [PRIO_BITS-1:0]    prio;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, req_type, prio, payload, input ready);
    modport sink   (input valid, req_type, prio, payload, output ready);
endinterface

interface spq_rsp_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(spq_pkg::DEPTH_DEF + 1)
);
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::STATUS_BITS-1:0] status;
    logic [PRIO_BITS-1:0]            out_prio;
    logic [PAYLOAD_BITS-1:0]         out_payload;
    logic [OCC_BITS-1:0]             occupancy;

    modport source (output valid, status, out_prio, out_payload, occupancy, input ready);
    modport sink   (input valid, status, out_prio, out_payload, occupancy, output ready);
endinterface

@@ hw/rtl/spq_cell.sv @@
// One storage cell of the sorted chain: compares against a pushed entry and shifts.
module spq_cell #(
    parameter int INDEX        = 0,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(spq_pkg::DEPTH_DEF + 1)
) (
    input  logic                    clk,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  logic [OCC_BITS-1:0]     fill,
    input  logic [PRIO_BITS-1:0]    new_prio,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    left_gt,
    input  logic [PRIO_BITS-1:0]    left_prio,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [PRIO_BITS-1:0]    right_prio,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                    gt,
    output logic [PRIO_BITS-1:0]    prio,
    output logic [PAYLOAD_BITS-1:0] payload
);
    import spq_pkg::*;

    localparam logic [OCC_BITS-1:0] MY_INDEX = OCC_BITS'(INDEX);

    logic [PRIO_BITS-1:0]    prio_reg;
    logic [PRIO_BITS-1:0]    prio_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    occupied;
    logic                    at_tail;

    // The cell holds a live entry when its place lies below the fill count.
    assign occupied = MY_INDEX < fill;
    assign at_tail  = MY_INDEX == fill;

    // A live entry with a larger priority must make room for the pushed one.
    assign gt = occupied && (prio_reg > new_prio);

    // On a push, cells behind the insertion point take their left neighbour's
    // entry and the insertion point itself takes the new one. On a pop every
    // cell takes its right neighbour's entry.
    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.push)
        begin
            if (left_gt)
            begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
            else if (gt || at_tail)
            begin
                prio_next    = new_prio;
                payload_next = new_payload;
            end
        end
        else if (ctrl.pop)
        begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    // Entry storage needs no reset; the fill count says what is live.
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

@@ hw/rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue: a chain of compare-and-shift cells with one result register.
// The response word to an accepted request word is registered and appears in the next cycle.
// Throughput: one request per cycle while request ready is high; every cell updates in parallel.
// Request ready is high whenever the response register is empty or being taken.
// Reset (rst_n low, asynchronous) empties the queue and clears the response valid;
// the cell contents are not cleared and are never read before being written.
module sorted_priority_queue_core #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(DEPTH + 1)
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam logic [OCC_BITS-1:0] FULL_COUNT = OCC_BITS'(DEPTH);

    logic [OCC_BITS-1:0]     fill_reg;
    logic [OCC_BITS-1:0]     fill_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [STATUS_BITS-1:0]  status_next;
    logic [PRIO_BITS-1:0]    out_prio_reg;
    logic [PRIO_BITS-1:0]    out_prio_next;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_next;
    logic [OCC_BITS-1:0]     occ_reg;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
    logic                    cell_gt      [DEPTH];

    // Handshake: a new request word may enter while the response register is empty or being taken.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full  = fill_reg == FULL_COUNT;
    assign is_empty = fill_reg == '0;

    assign ctrl.push = accept && (req.req_type == REQ_PUSH) && !is_full;
    assign ctrl.pop  = accept && (req.req_type == REQ_POP) && !is_empty;

    // Chain of cells; the ends see an empty left side and a held right side.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    left_gt;
        logic [PRIO_BITS-1:0]    left_prio;
        logic [PAYLOAD_BITS-1:0] left_payload;
        logic [PRIO_BITS-1:0]    right_prio;
        logic [PAYLOAD_BITS-1:0] right_payload;

        if (i == 0)
        begin : g_head
            assign left_gt      = 1'b0;
            assign left_prio    = '0;
            assign left_payload = '0;
        end
        else
        begin : g_body
            assign left_gt      = cell_gt[i-1];
            assign left_prio    = cell_prio[i-1];
            assign left_payload = cell_payload[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_prio    = cell_prio[i];
            assign right_payload = cell_payload[i];
        end
        else
        begin : g_inner
            assign right_prio    = cell_prio[i+1];
            assign right_payload = cell_payload[i+1];
        end

        spq_cell #(
            .INDEX        (i),
            .PRIO_BITS    (PRIO_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .OCC_BITS     (OCC_BITS)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .fill          (fill_reg),
            .new_prio      (req.prio),
            .new_payload   (req.payload),
            .left_gt       (left_gt),
            .left_prio     (left_prio),
            .left_payload  (left_payload),
            .right_prio    (right_prio),
            .right_payload (right_payload),
            .gt            (cell_gt[i]),
            .prio          (cell_prio[i]),
            .payload       (cell_payload[i])
        );
    end

    // Occupancy tracking and the response word built from the head cell.
    always_comb
    begin
        fill_next        = fill_reg;
        status_next      = status_reg;
        out_prio_next    = out_prio_reg;
        out_payload_next = out_payload_reg;
        rsp_valid_next   = rsp_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next   = 1'b1;
            status_next      = STATUS_DONE;
            out_prio_next    = '0;
            out_payload_next = '0;
            if (req.req_type == REQ_PUSH)
            begin
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    out_prio_next    = cell_prio[0];
                    out_payload_next = cell_payload[0];
                    fill_next        = fill_reg - 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        out_prio_reg    <= out_prio_next;
        out_payload_reg <= out_payload_next;
        if (accept)
        begin
            occ_reg <= fill_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_prio    = out_prio_reg;
    assign rsp.out_payload = out_payload_reg;
    assign rsp.occupancy   = occ_reg;

endmodule
